/* rtl/ifsm_pkg.sv */
package ifsm_pkg;

	localparam int VALUE_WIDTH = 24;
	localparam int TICK_W = 20;
	localparam int LIMIT_W = 23;
	localparam int LIMIT_SQ_W = 2 * LIMIT_W;
	localparam int TIME_W = 32;
	localparam int HC_W = 24;
	localparam int SQ_W = 48;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam int PROD_W = 2 * VALUE_WIDTH;
	localparam int SUM_W = PROD_W + 2;
	localparam int SUM_CMP_W = (SUM_W > SQ_W) ? SUM_W : SQ_W;
	localparam int HC_CMP_W = (VALUE_WIDTH > HC_W) ? VALUE_WIDTH : HC_W;

	typedef logic signed [VALUE_WIDTH-1:0] val_t;
	typedef val_t [2:0] vec_t;
	typedef logic [PROD_W-1:0] prod_t;
	typedef prod_t [2:0] prod_vec_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MONITOR_ENABLE    = 3'd0,
		CFG_MAX_HEIGHT_DELTA  = 3'd1,
		CFG_MAX_LINEAR_SPEED  = 3'd2,
		CFG_MAX_ANGULAR_SPEED = 3'd3,
		CFG_GRACE_PERIOD_US   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic                  enable;
		logic [LIMIT_W-1:0]    max_height;
		logic [LIMIT_SQ_W-1:0] linear_sq;
		logic [LIMIT_SQ_W-1:0] angular_sq;
		logic [TIME_W-1:0]     grace;
	} cfg_t;

endpackage

/* rtl/ifsm_sample_if.sv */
interface ifsm_sample_if;
	import ifsm_pkg::*;

	logic              valid;
	logic              ready;
	val_t              root_height;
	val_t              linear_vel_x;
	val_t              linear_vel_y;
	val_t              linear_vel_z;
	val_t              angular_vel_x;
	val_t              angular_vel_y;
	val_t              angular_vel_z;
	logic [TICK_W-1:0] tick_time_us;

	modport source (
		output valid, root_height, linear_vel_x, linear_vel_y, linear_vel_z,
		       angular_vel_x, angular_vel_y, angular_vel_z, tick_time_us,
		input  ready
	);
	modport sink (
		input  valid, root_height, linear_vel_x, linear_vel_y, linear_vel_z,
		       angular_vel_x, angular_vel_y, angular_vel_z, tick_time_us,
		output ready
	);
endinterface

/* rtl/ifsm_result_if.sv */
interface ifsm_result_if;
	import ifsm_pkg::*;

	logic              valid;
	logic              ready;
	logic              fail_stop;
	logic              height_exceeded;
	logic              linear_exceeded;
	logic              angular_exceeded;
	logic [HC_W-1:0]   height_change;
	logic [SQ_W-1:0]   linear_speed_sq;
	logic [SQ_W-1:0]   angular_speed_sq;
	logic [TIME_W-1:0] unstable_time_out;

	modport source (
		output valid, fail_stop, height_exceeded, linear_exceeded, angular_exceeded,
		       height_change, linear_speed_sq, angular_speed_sq, unstable_time_out,
		input  ready
	);
	modport sink (
		input  valid, fail_stop, height_exceeded, linear_exceeded, angular_exceeded,
		       height_change, linear_speed_sq, angular_speed_sq, unstable_time_out,
		output ready
	);
endinterface

/* rtl/ifsm_cfg_if.sv */
interface ifsm_cfg_if;
	import ifsm_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/ifsm_cfg_regs.sv */
module ifsm_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	ifsm_cfg_if.sink       cfg,
	output ifsm_pkg::cfg_t cfg_out
);
	import ifsm_pkg::*;

	logic               enable_q;
	logic [LIMIT_W-1:0] max_height_q;
	logic [LIMIT_W-1:0] max_linear_q;
	logic [LIMIT_W-1:0] max_angular_q;
	logic [TIME_W-1:0]  grace_q;
	logic [LIMIT_SQ_W-1:0] linear_sq_q;
	logic [LIMIT_SQ_W-1:0] angular_sq_q;
	logic               wr;

	assign cfg.ready = 1'b1;
	assign wr = cfg.valid & cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b0;
			max_height_q  <= '0;
			max_linear_q  <= '0;
			max_angular_q <= '0;
			grace_q       <= '0;
		end else if (wr) begin
			case (cfg_reg_t'(cfg.index))
				CFG_MONITOR_ENABLE:    enable_q      <= cfg.data[0];
				CFG_MAX_HEIGHT_DELTA:  max_height_q  <= cfg.data[LIMIT_W-1:0];
				CFG_MAX_LINEAR_SPEED:  max_linear_q  <= cfg.data[LIMIT_W-1:0];
				CFG_MAX_ANGULAR_SPEED: max_angular_q <= cfg.data[LIMIT_W-1:0];
				CFG_GRACE_PERIOD_US:   grace_q       <= cfg.data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// squared limits, registered from the stored speed limits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			linear_sq_q  <= '0;
			angular_sq_q <= '0;
		end else begin
			linear_sq_q  <= max_linear_q * max_linear_q;
			angular_sq_q <= max_angular_q * max_angular_q;
		end
	end

	always_comb begin
		cfg_out.enable     = enable_q;
		cfg_out.max_height = max_height_q;
		cfg_out.linear_sq  = linear_sq_q;
		cfg_out.angular_sq = angular_sq_q;
		cfg_out.grace      = grace_q;
	end
endmodule

/* rtl/ifsm_capture.sv */
module ifsm_capture (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  ifsm_pkg::val_t                root_height,
	input  ifsm_pkg::vec_t                linear_vel,
	input  ifsm_pkg::vec_t                angular_vel,
	input  logic [ifsm_pkg::TICK_W-1:0]   tick_time_us,
	output logic [ifsm_pkg::VALUE_WIDTH-1:0] hc_s1,
	output ifsm_pkg::vec_t                linear_s1,
	output ifsm_pkg::vec_t                angular_s1,
	output logic [ifsm_pkg::TICK_W-1:0]   tick_s1
);
	import ifsm_pkg::*;

	logic                    ref_latched_q;
	val_t                    ref_height_q;
	val_t                    ref_sel;
	logic signed [VALUE_WIDTH:0] diff;
	logic [VALUE_WIDTH:0]    diff_abs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_latched_q <= 1'b0;
			ref_height_q  <= '0;
		end else if (load && !ref_latched_q) begin
			ref_latched_q <= 1'b1;
			ref_height_q  <= root_height;
		end
	end

	assign ref_sel  = ref_latched_q ? ref_height_q : root_height;
	assign diff     = (VALUE_WIDTH+1)'(root_height) - (VALUE_WIDTH+1)'(ref_sel);
	assign diff_abs = diff[VALUE_WIDTH] ? $unsigned(-diff) : $unsigned(diff);

	always_ff @(posedge clk) begin
		if (load) begin
			hc_s1      <= diff_abs[VALUE_WIDTH-1:0];
			linear_s1  <= linear_vel;
			angular_s1 <= angular_vel;
			tick_s1    <= tick_time_us;
		end
	end
endmodule

/* rtl/ifsm_square.sv */
module ifsm_square (
	input  logic                clk,
	input  logic                load,
	input  ifsm_pkg::vec_t      vec,
	output ifsm_pkg::prod_vec_t sq_s2
);
	import ifsm_pkg::*;

	logic [VALUE_WIDTH-1:0] mag [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = vec[i][VALUE_WIDTH-1] ? $unsigned(-vec[i]) : $unsigned(vec[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= mag[i] * mag[i];
			end
		end
	end
endmodule

/* rtl/ifsm_decide.sv */
module ifsm_decide (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             load,
	input  ifsm_pkg::cfg_t                   cfg,
	input  logic [ifsm_pkg::VALUE_WIDTH-1:0] hc_s2,
	input  ifsm_pkg::prod_vec_t              linear_sq_s2,
	input  ifsm_pkg::prod_vec_t              angular_sq_s2,
	input  logic [ifsm_pkg::TICK_W-1:0]      tick_s2,
	output logic                             fail_stop_s3,
	output logic                             height_exc_s3,
	output logic                             linear_exc_s3,
	output logic                             angular_exc_s3,
	output logic [ifsm_pkg::HC_W-1:0]        height_change_s3,
	output logic [ifsm_pkg::SQ_W-1:0]        linear_sq_s3,
	output logic [ifsm_pkg::SQ_W-1:0]        angular_sq_s3,
	output logic [ifsm_pkg::TIME_W-1:0]      unstable_s3
);
	import ifsm_pkg::*;

	localparam logic [SUM_CMP_W-1:0] SQ_CAP = SUM_CMP_W'({SQ_W{1'b1}});
	localparam logic [HC_CMP_W-1:0]  HC_CAP = HC_CMP_W'({HC_W{1'b1}});

	logic [TIME_W-1:0]    unstable_q;
	logic [SUM_CMP_W-1:0] lin_sum;
	logic [SUM_CMP_W-1:0] ang_sum;
	logic [HC_CMP_W-1:0]  hc_ext;
	logic [SQ_W-1:0]      lin_sat;
	logic [SQ_W-1:0]      ang_sat;
	logic [HC_W-1:0]      hc_sat;
	logic                 he, le, ae;
	logic [TIME_W:0]      ut_sum;
	logic [TIME_W-1:0]    ut_next;
	logic                 fail;

	always_comb begin
		lin_sum = SUM_CMP_W'(linear_sq_s2[0]) + SUM_CMP_W'(linear_sq_s2[1])
		        + SUM_CMP_W'(linear_sq_s2[2]);
		ang_sum = SUM_CMP_W'(angular_sq_s2[0]) + SUM_CMP_W'(angular_sq_s2[1])
		        + SUM_CMP_W'(angular_sq_s2[2]);
		hc_ext  = HC_CMP_W'(hc_s2);
		lin_sat = (lin_sum > SQ_CAP) ? {SQ_W{1'b1}} : lin_sum[SQ_W-1:0];
		ang_sat = (ang_sum > SQ_CAP) ? {SQ_W{1'b1}} : ang_sum[SQ_W-1:0];
		hc_sat  = (hc_ext > HC_CAP) ? {HC_W{1'b1}} : hc_ext[HC_W-1:0];

		he = hc_sat > HC_W'(cfg.max_height);
		le = lin_sat > SQ_W'(cfg.linear_sq);
		ae = ang_sat > SQ_W'(cfg.angular_sq);

		ut_sum  = {1'b0, unstable_q} + (TIME_W+1)'(tick_s2);
		ut_next = '0;
		if (he || le || ae) begin
			ut_next = ut_sum[TIME_W] ? {TIME_W{1'b1}} : ut_sum[TIME_W-1:0];
		end
		fail = ut_next >= cfg.grace;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unstable_q <= '0;
		end else if (load && cfg.enable) begin
			unstable_q <= ut_next;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (cfg.enable) begin
				fail_stop_s3     <= fail;
				height_exc_s3    <= he;
				linear_exc_s3    <= le;
				angular_exc_s3   <= ae;
				height_change_s3 <= hc_sat;
				linear_sq_s3     <= lin_sat;
				angular_sq_s3    <= ang_sat;
				unstable_s3      <= ut_next;
			end else begin
				fail_stop_s3     <= 1'b0;
				height_exc_s3    <= 1'b0;
				linear_exc_s3    <= 1'b0;
				angular_exc_s3   <= 1'b0;
				height_change_s3 <= '0;
				linear_sq_s3     <= '0;
				angular_sq_s3    <= '0;
				unstable_s3      <= '0;
			end
		end
	end
endmodule

/* rtl/instability_fail_stop_monitor_top.sv */
// Root instability fail-stop monitor.
// sample: one request per control tick carrying root height, linear and
//   angular velocity vectors and the tick length in microseconds.
// result: one request per sample with the exceed flags, absolute height
//   change, squared speeds, accumulated unstable time and fail_stop.
// cfg: register writes (enable, limits, grace period); always ready. Write
//   only while no sample is in flight. Squared limits are registered
//   from the stored limit values.
// Pipeline: an accepted sample passes the capture, squaring and result
//   registers in that order; result.valid is the last stage's valid flag.
// Throughput: one sample per cycle while result is taken; the three 24x24
//   squares per vector sit in their own register stage; compare stays short.
// Reset: the valid flags, config registers, latched reference height and
//   unstable time clear; the first sample after reset latches the reference.
// Stall: when result is not taken, each stage holds its request and
//   sample.ready drops once all three stages are full.
module instability_fail_stop_monitor_top (
	input  logic        clk,
	input  logic        arst_n,
	ifsm_sample_if.sink sample,
	ifsm_result_if.source result,
	ifsm_cfg_if.sink    cfg
);
	import ifsm_pkg::*;

	cfg_t cfg_val;

	logic valid_s1, valid_s2, valid_s3;
	logic ready1, ready2, ready3;
	logic load1, load2, load3;

	logic [VALUE_WIDTH-1:0] hc_s1;
	vec_t                   linear_s1;
	vec_t                   angular_s1;
	logic [TICK_W-1:0]      tick_s1;
	logic [VALUE_WIDTH-1:0] hc_s2;
	logic [TICK_W-1:0]      tick_s2;
	prod_vec_t              linear_sq_s2;
	prod_vec_t              angular_sq_s2;
	vec_t                   lin_in;
	vec_t                   ang_in;

	assign ready3 = !valid_s3 || result.ready;
	assign ready2 = !valid_s2 || ready3;
	assign ready1 = !valid_s1 || ready2;
	assign sample.ready = ready1;
	assign load1 = sample.valid && ready1;
	assign load2 = valid_s1 && ready2;
	assign load3 = valid_s2 && ready3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready1) valid_s1 <= sample.valid;
			if (ready2) valid_s2 <= valid_s1;
			if (ready3) valid_s3 <= valid_s2;
		end
	end

	assign lin_in = {sample.linear_vel_z, sample.linear_vel_y, sample.linear_vel_x};
	assign ang_in = {sample.angular_vel_z, sample.angular_vel_y, sample.angular_vel_x};

	ifsm_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_out (cfg_val)
	);

	ifsm_capture u_capture (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load1),
		.root_height  (sample.root_height),
		.linear_vel   (lin_in),
		.angular_vel  (ang_in),
		.tick_time_us (sample.tick_time_us),
		.hc_s1        (hc_s1),
		.linear_s1    (linear_s1),
		.angular_s1   (angular_s1),
		.tick_s1      (tick_s1)
	);

	ifsm_square u_sq_linear (
		.clk   (clk),
		.load  (load2),
		.vec   (linear_s1),
		.sq_s2 (linear_sq_s2)
	);

	ifsm_square u_sq_angular (
		.clk   (clk),
		.load  (load2),
		.vec   (angular_s1),
		.sq_s2 (angular_sq_s2)
	);

	always_ff @(posedge clk) begin
		if (load2) begin
			hc_s2   <= hc_s1;
			tick_s2 <= tick_s1;
		end
	end

	ifsm_decide u_decide (
		.clk              (clk),
		.arst_n           (arst_n),
		.load             (load3),
		.cfg              (cfg_val),
		.hc_s2            (hc_s2),
		.linear_sq_s2     (linear_sq_s2),
		.angular_sq_s2    (angular_sq_s2),
		.tick_s2          (tick_s2),
		.fail_stop_s3     (result.fail_stop),
		.height_exc_s3    (result.height_exceeded),
		.linear_exc_s3    (result.linear_exceeded),
		.angular_exc_s3   (result.angular_exceeded),
		.height_change_s3 (result.height_change),
		.linear_sq_s3     (result.linear_speed_sq),
		.angular_sq_s3    (result.angular_speed_sq),
		.unstable_s3      (result.unstable_time_out)
	);

	assign result.valid = valid_s3;
endmodule
